/* design/sat_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_pkg: shared types and constants of the sorted array table
// Field widths, action and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package sat_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int DATA_W   = 32;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int FILL_W   = 5;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_action ACT_INSERT = 2'd0;
    localparam t_action ACT_REMOVE = 2'd1;
    localparam t_action ACT_SEARCH = 2'd2;
    localparam t_action ACT_NOP    = 2'd3;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_FULL    = 2'd1;
    localparam t_status ST_MISSING = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_WR,
        S_SRCH,
        S_SRCH_CMP,
        S_RM_RD,
        S_RM_MV,
        S_DONE
    } t_state;

endpackage

/* design/sat_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_if: request and result channels of the sorted array table
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sat_in_if import sat_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ACTION_W-1:0]      action;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, action, value, input ready);
    modport sink   (input valid, action, value, output ready);
endinterface

interface sat_out_if import sat_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [FILL_W-1:0]   fill_count;

    modport source (output valid, status, position, fill_count, input ready);
    modport sink   (input valid, status, position, fill_count, output ready);
endinterface

/* design/sorted_array_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_array_table_top: sorted table with insert, remove and binary search
// Keeps up to CAPACITY signed words in ascending order in one RAM.
//
//   channel  dir  word fields                      accepted when
//   i_in     in   action, value                    valid && ready
//   o_res    out  status, position, fill_count     valid && ready
//
// Steps from acceptance to result: insert moves each larger entry up one
//   place, then writes the word (full: straight to result); search reads the
//   middle entry once per halving step; remove runs a found search and then
//   moves each later entry down one place.
// Reset clears the count and the result valid; the RAM needs no clearing.
// One word in flight; the next is taken while the last result waits, and a
// stalled result holds completion of the following word.
// ----------------------------------------------------------------------------
module sorted_array_table_top import sat_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sat_in_if.sink    i_in,
    sat_out_if.source o_res
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    t_state                   r_state,  n_state;
    logic [CW-1:0]            r_count,  n_count;
    logic [AW-1:0]            r_idx,    n_idx;
    logic [CW-1:0]            r_lo,     n_lo;
    logic [CW-1:0]            r_hix,    n_hix;
    logic [AW-1:0]            r_mid,    n_mid;
    logic [AW-1:0]            r_pos,    n_pos;
    logic signed [DATA_W-1:0] r_value,  n_value;
    t_action                  r_action, n_action;
    t_status                  r_status, n_status;
    logic                     r_ov,     n_ov;
    t_status                  r_o_status, n_o_status;
    logic [POS_W-1:0]         r_o_pos,    n_o_pos;
    logic [FILL_W-1:0]        r_o_cnt,    n_o_cnt;

    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic [DATA_W-1:0]        w_wdata;
    logic [AW-1:0]            w_raddr;
    logic [DATA_W-1:0]        w_rdata;

    logic [CW:0]              w_sum;
    logic [CW:0]              w_idx_x;
    logic [CW:0]              w_cnt_x;
    logic [CW-1:0]            w_cm1;
    logic [AW+POS_W-1:0]      w_pos_x;
    logic [CW+FILL_W-1:0]     w_cnt_o;

    sat_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_sum   = {1'b0, r_lo} + {1'b0, r_hix} - (CW+1)'(1);
    assign w_idx_x = (CW+1)'(r_idx);
    assign w_cnt_x = {1'b0, r_count};
    assign w_cm1   = r_count - CW'(1);
    assign w_pos_x = (AW+POS_W)'(r_pos);
    assign w_cnt_o = (CW+FILL_W)'(r_count);

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_res.valid      = r_ov;
    assign o_res.status     = r_o_status;
    assign o_res.position   = r_o_pos;
    assign o_res.fill_count = r_o_cnt;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_lo       = r_lo;
        n_hix      = r_hix;
        n_mid      = r_mid;
        n_pos      = r_pos;
        n_value    = r_value;
        n_action   = r_action;
        n_status   = r_status;
        n_ov       = r_ov;
        n_o_status = r_o_status;
        n_o_pos    = r_o_pos;
        n_o_cnt    = r_o_cnt;
        w_we       = 1'b0;
        w_waddr    = r_idx;
        w_wdata    = r_value;
        w_raddr    = r_idx;

        if (r_ov && o_res.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_value  = i_in.value;
                    n_action = i_in.action;
                    n_status = ST_OK;
                    n_pos    = '0;
                    n_lo     = '0;
                    n_hix    = r_count;
                    case (i_in.action)
                        ACT_INSERT: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else if (r_count == '0) begin
                                n_idx   = '0;
                                n_state = S_INS_WR;
                            end else begin
                                n_idx   = r_count[AW-1:0];
                                w_raddr = w_cm1[AW-1:0];
                                n_state = S_INS_CMP;
                            end
                        end
                        ACT_REMOVE, ACT_SEARCH: begin
                            n_state = S_SRCH;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_INS_CMP: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                if (r_value < $signed(w_rdata)) begin
                    w_wdata = w_rdata;
                    n_idx   = r_idx - AW'(1);
                    if (r_idx == AW'(1)) begin
                        n_state = S_INS_WR;
                    end else begin
                        w_raddr = r_idx - AW'(2);
                    end
                end else begin
                    w_wdata = r_value;
                    n_count = r_count + CW'(1);
                    n_state = S_DONE;
                end
            end
            S_INS_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = r_value;
                n_count = r_count + CW'(1);
                n_state = S_DONE;
            end
            S_SRCH: begin
                if (r_lo < r_hix) begin
                    n_mid   = w_sum[AW:1];
                    w_raddr = w_sum[AW:1];
                    n_state = S_SRCH_CMP;
                end else begin
                    n_status = ST_MISSING;
                    n_state  = S_DONE;
                end
            end
            S_SRCH_CMP: begin
                if ($signed(w_rdata) == r_value) begin
                    n_pos = r_mid;
                    if (r_action == ACT_REMOVE) begin
                        n_idx   = r_mid;
                        n_state = S_RM_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if ($signed(w_rdata) < r_value) begin
                    n_lo    = CW'(r_mid) + CW'(1);
                    n_state = S_SRCH;
                end else begin
                    n_hix   = CW'(r_mid);
                    n_state = S_SRCH;
                end
            end
            S_RM_RD: begin
                if ((w_idx_x + (CW+1)'(1)) < w_cnt_x) begin
                    w_raddr = r_idx + AW'(1);
                    n_state = S_RM_MV;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_RM_MV: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = w_rdata;
                n_idx   = r_idx + AW'(1);
                if ((w_idx_x + (CW+1)'(2)) < w_cnt_x) begin
                    w_raddr = r_idx + AW'(2);
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ov || o_res.ready) begin
                    n_ov       = 1'b1;
                    n_o_status = r_status;
                    n_o_pos    = w_pos_x[POS_W-1:0];
                    n_o_cnt    = w_cnt_o[FILL_W-1:0];
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_lo       <= n_lo;
        r_hix      <= n_hix;
        r_mid      <= n_mid;
        r_pos      <= n_pos;
        r_value    <= n_value;
        r_action   <= n_action;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_pos    <= n_o_pos;
        r_o_cnt    <= n_o_cnt;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |-> (r_state == S_DONE))
        else $error("entry count moved outside completion");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state != S_IDLE) && (r_state != S_DONE)))
        else $error("RAM write while not working on a word");

    a_write_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((CW+1)'(w_waddr) < (CW+1)'(CAPACITY)))
        else $error("RAM write beyond capacity");

endmodule

/* design/sat_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sorted array table
// A clocked driver sends action/value words from a queue, and a scoreboard
// keeps its own sorted table to predict status, position and fill count.
// A clocked monitor takes each result word and compares it with the oldest
// prediction. Both sides idle at random, except for one quiet stretch.
// The stimulus starts with directed corners (empty, equal values, extremes,
// full, unused action) and then runs random fill, drain and mixed phases.
// ----------------------------------------------------------------------------
module testbench import sat_pkg::*; ();

    localparam int CAP          = CAPACITY_DEF;
    localparam int RANDOM_WORDS = 1250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 64;
    localparam int IDLE_PCT     = 23;
    localparam int QUIET_LO     = 500;
    localparam int QUIET_HI     = 700;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        t_action             action;
        logic [DATA_W-1:0]   value;
    } t_word;

    typedef struct packed {
        t_status             status;
        logic [POS_W-1:0]    position;
        logic [FILL_W-1:0]   fill_count;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    sat_in_if  req_if ();
    sat_out_if res_if ();

    sorted_array_table_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_res   (res_if)
    );

    t_word                    pending_words[$];
    t_answer                  answers_due[$];
    logic signed [DATA_W-1:0] sorted_vals[CAP];
    int                       held_count;
    int                       error_count;
    int                       words_taken;
    int                       results_seen;
    logic signed [DATA_W-1:0] gen_pool[$];
    t_word                    next_word;
    t_answer                  got_answer;
    t_answer                  due_answer;
    logic                     stall_in;
    logic                     stall_out;

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.action = ACT_INSERT;
        req_if.value  = '0;
        res_if.ready  = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_answer apply_word(t_action act, logic signed [DATA_W-1:0] v);
        t_answer ans;
        int      i;
        int      lo;
        int      hi;
        int      mid;
        int      where;
        logic    found;
        ans    = '0;
        ans.status = ST_OK;
        found  = 1'b0;
        where  = 0;
        if (act == ACT_INSERT) begin
            if (held_count >= CAP) begin
                ans.status = ST_FULL;
            end else begin
                i = held_count;
                while (i > 0 && v < sorted_vals[i-1]) begin
                    sorted_vals[i] = sorted_vals[i-1];
                    i--;
                end
                sorted_vals[i] = v;
                held_count++;
            end
        end else if (act == ACT_REMOVE || act == ACT_SEARCH) begin
            lo = 0;
            hi = held_count - 1;
            while (lo <= hi && !found) begin
                mid = (lo + hi) / 2;
                if (sorted_vals[mid] == v) begin
                    found = 1'b1;
                    where = mid;
                end else if (sorted_vals[mid] < v) begin
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end
            if (!found) begin
                ans.status = ST_MISSING;
            end else begin
                ans.position = where[POS_W-1:0];
                if (act == ACT_REMOVE) begin
                    for (i = where; i + 1 < held_count; i++)
                        sorted_vals[i] = sorted_vals[i+1];
                    held_count--;
                end
            end
        end
        ans.fill_count = held_count[FILL_W-1:0];
        return ans;
    endfunction

    // queue a word and track which values the table will hold
    task automatic add_word(t_action act, logic signed [DATA_W-1:0] v);
        t_word w;
        int    k;
        logic  gone;
        w.action = act;
        w.value  = v;
        pending_words.push_back(w);
        gone = 1'b0;
        if (act == ACT_INSERT && gen_pool.size() < CAP) begin
            gen_pool.push_back(v);
        end else if (act == ACT_REMOVE) begin
            for (k = 0; k < gen_pool.size() && !gone; k++) begin
                if (gen_pool[k] == v) begin
                    gen_pool.delete(k);
                    gone = 1'b1;
                end
            end
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(bit prefer_held);
        int roll;
        roll = $urandom_range(99);
        if (gen_pool.size() != 0 && roll < (prefer_held ? 70 : 30))
            return gen_pool[$urandom_range(gen_pool.size() - 1)];
        roll = $urandom_range(99);
        if (roll < 45)
            return $signed($urandom_range(16)) - 8;
        if (roll < 65) begin
            case ($urandom_range(5))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'sh7FFF_FFFE;
                3: return 32'sh8000_0001;
                4: return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        return $urandom;
    endfunction

    task automatic build_random();
        int   n;
        int   mode;
        int   run_left;
        int   roll;
        int   ins_pct;
        int   rem_pct;
        n        = 0;
        mode     = 0;
        run_left = 0;
        while (n < RANDOM_WORDS) begin
            if (run_left == 0) begin
                mode     = $urandom_range(2);
                run_left = $urandom_range(60, 20);
            end
            case (mode)
                0:       begin ins_pct = 65; rem_pct = 10; end
                1:       begin ins_pct = 15; rem_pct = 55; end
                default: begin ins_pct = 35; rem_pct = 30; end
            endcase
            roll = $urandom_range(99);
            if (roll < 2)
                add_word(ACT_NOP, $urandom);
            else if (roll < 2 + ins_pct)
                add_word(ACT_INSERT, pick_value(1'b0));
            else if (roll < 2 + ins_pct + rem_pct)
                add_word(ACT_REMOVE, pick_value(1'b1));
            else
                add_word(ACT_SEARCH, pick_value(1'b1));
            run_left--;
            n++;
        end
    endtask

    task automatic build_directed();
        add_word(ACT_SEARCH, 32'sd0);
        add_word(ACT_REMOVE, 32'sd0);
        add_word(ACT_NOP, 32'sd5);
        add_word(ACT_INSERT, 32'sh7FFF_FFFF);
        add_word(ACT_INSERT, 32'sh8000_0000);
        add_word(ACT_INSERT, 32'sd0);
        add_word(ACT_INSERT, 32'sd0);
        add_word(ACT_INSERT, -32'sd1);
        add_word(ACT_INSERT, 32'sd1);
        add_word(ACT_INSERT, 32'sd0);
        add_word(ACT_INSERT, 32'sd100);
        add_word(ACT_INSERT, -32'sd100);
        add_word(ACT_INSERT, 32'sh5555_5555);
        add_word(ACT_INSERT, 32'shAAAA_AAAA);
        add_word(ACT_INSERT, 32'sd7);
        add_word(ACT_INSERT, 32'sd7);
        add_word(ACT_INSERT, -32'sd7);
        add_word(ACT_INSERT, 32'sh7FFF_FFFE);
        add_word(ACT_INSERT, 32'sh8000_0001);
        add_word(ACT_INSERT, 32'sd5);
        add_word(ACT_NOP, 32'sh8000_0000);
        add_word(ACT_SEARCH, 32'sd0);
        add_word(ACT_SEARCH, 32'sd7);
        add_word(ACT_SEARCH, 32'sh8000_0000);
        add_word(ACT_SEARCH, 32'sh7FFF_FFFF);
        add_word(ACT_SEARCH, 32'sd8);
        add_word(ACT_REMOVE, 32'sh7FFF_FFFF);
        add_word(ACT_REMOVE, 32'sh8000_0000);
        add_word(ACT_REMOVE, 32'sd42);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                answers_due.push_back(apply_word(req_if.action, req_if.value));
                words_taken++;
            end
            if (!req_if.valid || req_if.ready) begin
                stall_in = (words_taken >= QUIET_LO && words_taken < QUIET_HI) ? 1'b0
                         : ($urandom_range(99) < IDLE_PCT);
                if (pending_words.size() != 0 && !stall_in) begin
                    next_word = pending_words.pop_front();
                    req_if.valid  <= 1'b1;
                    req_if.action <= next_word.action;
                    req_if.value  <= next_word.value;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                results_seen++;
                got_answer.status     = res_if.status;
                got_answer.position   = res_if.position;
                got_answer.fill_count = res_if.fill_count;
                if (answers_due.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected result: status %0d position %0d fill %0d",
                                 got_answer.status, got_answer.position,
                                 got_answer.fill_count);
                end else begin
                    due_answer = answers_due.pop_front();
                    if (got_answer.status     !== due_answer.status   ||
                        got_answer.position   !== due_answer.position ||
                        got_answer.fill_count !== due_answer.fill_count) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $write("result %0d mismatch: status %0d/%0d position %0d/%0d",
                                   results_seen,
                                   due_answer.status, got_answer.status,
                                   due_answer.position, got_answer.position);
                            $display(" fill %0d/%0d (expected/actual)",
                                     due_answer.fill_count, got_answer.fill_count);
                        end
                    end
                end
            end
            stall_out = (results_seen >= QUIET_LO && results_seen < QUIET_HI) ? 1'b0
                      : ($urandom_range(99) < IDLE_PCT);
            res_if.ready <= !stall_out;
        end
    end

    initial begin
        held_count   = 0;
        error_count  = 0;
        words_taken  = 0;
        results_seen = 0;
        build_directed();
        build_random();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_words.size() != 0 || req_if.valid) @(posedge i_clk);
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (error_count == 0 && answers_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
